@@ rtl/core/u256_pkg.sv @@
// Shared types and constants for the 256-bit integer unit.
package u256_pkg;
	localparam int NUM_WORDS_DEF = 8;
	localparam int WORD_W = 32;

	typedef enum logic [3:0] {
		CMD_LOADA = 4'd0, CMD_LOADB = 4'd1, CMD_ADD = 4'd2, CMD_SUB = 4'd3,
		CMD_SHL = 4'd4, CMD_SHR = 4'd5, CMD_INV = 4'd6, CMD_DIV = 4'd7,
		CMD_COMPACT = 4'd8, CMD_READ = 4'd9
	} cmd_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [2:0]  word_index;
		logic [31:0] data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_word;
		logic        a_less_b;
		logic        a_equal_b;
		logic        div_by_zero;
		logic        compact_negative;
		logic        compact_overflow;
	} out_item_t;

	localparam logic [31:0] MANT_MASK = 32'h007fffff;
	localparam logic [31:0] SIGN_BIT  = 32'h00800000;
	localparam logic [22:0] MANT_BYTE = 23'hff;
	localparam logic [22:0] MANT_HALF = 23'hffff;
endpackage

@@ rtl/core/uint256_arith_unit_top.sv @@
// Top level of the 256-bit integer unit.
// Each command but a divide with nonzero B gives its result strobe the cycle after
// it is accepted. A divide with nonzero B runs the divider, one quotient bit per
// cycle through its single subtractor; busy is high meanwhile and drops as the
// result strobe rises. One command per cycle is taken while busy is low; the
// receiver cannot stall.
// Reset clears A, B and all control state.
module uint256_arith_unit_top
	import u256_pkg::*;
#(
	parameter int NUM_WORDS = NUM_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  u256_pkg::in_item_t  cmd_in,
	output logic                busy,
	output logic                result_valid,
	output u256_pkg::out_item_t result
);
	localparam int W = NUM_WORDS * WORD_W;
	localparam int LIM = NUM_WORDS * 4;

	logic [W-1:0] a_q, b_q;
	logic         busy_q, rv_q;
	logic [2:0]   idx_q;
	logic         dz_q, neg_q, ovf_q;
	logic         div_go, div_done;
	logic [W-1:0] quo;
	logic [W-1:0] a_nx;
	logic         neg_nx, ovf_nx, dz_nx;
	logic         accept;

	assign accept = start && !busy_q;

	u256_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(a_q), .divisor(b_q), .done(div_done), .quotient(quo)
	);

	logic [7:0]  csize;
	logic [22:0] cmant, cm_sh;
	logic [W-1:0] cm_w;

	always_comb begin
		a_nx = a_q;
		neg_nx = 1'b0;
		ovf_nx = 1'b0;
		dz_nx = 1'b0;
		div_go = 1'b0;
		csize = cmd_in.data[31:24];
		cmant = cmd_in.data[22:0];
		cm_sh = cmant;
		cm_w = '0;
		case (cmd_in.cmd)
			CMD_LOADA: if (32'(cmd_in.word_index) < NUM_WORDS)
				a_nx[cmd_in.word_index*WORD_W +: WORD_W] = cmd_in.data;
			CMD_ADD: a_nx = a_q + b_q;
			CMD_SUB: a_nx = a_q - b_q;
			CMD_SHL: a_nx = (cmd_in.data >= 32'(W)) ? '0 : a_q << cmd_in.data;
			CMD_SHR: a_nx = (cmd_in.data >= 32'(W)) ? '0 : a_q >> cmd_in.data;
			CMD_INV: a_nx = ~a_q;
			CMD_DIV: begin
				if (b_q == '0) dz_nx = 1'b1;
				else div_go = accept;
			end
			CMD_COMPACT: begin
				if (csize <= 8'd3) begin
					cm_sh = cmant >> (5'd8 * (5'd3 - csize[4:0]));
					a_nx = W'(cm_sh);
				end else begin
					cm_w = W'(cmant);
					a_nx = (32'(csize) - 32'd3 >= 32'(W / 8)) ? '0
						: cm_w << (11'(csize - 8'd3) * 11'd8);
				end
				neg_nx = (cm_sh != '0) && cmd_in.data[23];
				ovf_nx = (cm_sh != '0) && ((32'(csize) > LIM + 2) ||
					(cm_sh > MANT_BYTE && 32'(csize) > LIM + 1) ||
					(cm_sh > MANT_HALF && 32'(csize) > LIM));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			busy_q <= 1'b0;
			rv_q <= 1'b0;
			idx_q <= '0;
			dz_q <= 1'b0;
			neg_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			rv_q <= 1'b0;
			if (accept) begin
				idx_q <= cmd_in.word_index;
				dz_q <= dz_nx;
				neg_q <= neg_nx;
				ovf_q <= ovf_nx;
				if (cmd_in.cmd == CMD_LOADB && 32'(cmd_in.word_index) < NUM_WORDS)
					b_q[cmd_in.word_index*WORD_W +: WORD_W] <= cmd_in.data;
				if (div_go) busy_q <= 1'b1;
				else begin
					a_q <= a_nx;
					rv_q <= 1'b1;
				end
			end else if (busy_q && div_done) begin
				a_q <= quo;
				busy_q <= 1'b0;
				rv_q <= 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign result_valid = rv_q;
	assign result.read_word = (32'(idx_q) < NUM_WORDS) ? a_q[idx_q*WORD_W +: WORD_W] : '0;
	assign result.a_less_b = a_q < b_q;
	assign result.a_equal_b = a_q == b_q;
	assign result.div_by_zero = dz_q;
	assign result.compact_negative = neg_q;
	assign result.compact_overflow = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> busy_q)
		else $error("divider finished while idle");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q && !div_done |=> !rv_q)
		else $error("result during division");
	assert property (@(posedge clk) disable iff (!arst_n) rv_q |-> !(dz_q && (neg_q || ovf_q)))
		else $error("flags from different commands");
endmodule

@@ rtl/core/u256_div.sv @@
// Restoring divider: one quotient bit per cycle through one wide subtractor.
module u256_div #(
	parameter int W = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend bits out of quo_q top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !run_q)
		else $error("divider done while running");
	assert property (@(posedge clk) disable iff (!arst_n) go |=> run_q)
		else $error("divider did not start");
endmodule

@@ bench/uint256_arith_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the 256-bit integer unit: models A and B, predicts each result beat and compares.
module uint256_arith_unit_checker
	import u256_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  cmd_in,
	input  logic      result_valid,
	input  out_item_t result,
	output int        fail_count,
	output int        pending,
	output int        beats_seen
);
	localparam int NW = NUM_WORDS_DEF;
	localparam int NB = NW * WORD_W;

	logic [NB-1:0] acc;
	logic [NB-1:0] opnd;
	out_item_t     expected_q[$];

	assign pending = expected_q.size();

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH beat %0d %s: got %h want %h", beats_seen, what, got, want);
		fail_count++;
	endtask

	// restoring division, remainder keeps its carry-out bit
	function automatic logic [NB-1:0] quotient_of(input logic [NB-1:0] n,
			input logic [NB-1:0] d);
		logic [NB:0]   rem;
		logic [NB-1:0] q;
		rem = '0;
		q = '0;
		for (int i = NB - 1; i >= 0; i--) begin
			rem = {rem[NB-1:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic out_item_t predict_command(input in_item_t it);
		out_item_t r;
		logic [7:0]  size;
		logic [22:0] mant;
		r = '0;
		case (cmd_t'(it.cmd))
			CMD_LOADA: acc[it.word_index*32 +: 32] = it.data;
			CMD_LOADB: opnd[it.word_index*32 +: 32] = it.data;
			CMD_ADD: acc = acc + opnd;
			CMD_SUB: acc = acc - opnd;
			CMD_SHL: acc = (it.data >= NB) ? '0 : acc << it.data;
			CMD_SHR: acc = (it.data >= NB) ? '0 : acc >> it.data;
			CMD_INV: acc = ~acc;
			CMD_DIV: begin
				if (opnd == '0) r.div_by_zero = 1'b1;
				else acc = quotient_of(acc, opnd);
			end
			CMD_COMPACT: begin
				size = it.data[31:24];
				mant = it.data[22:0];
				if (size <= 3) begin
					mant = mant >> (8 * (3 - size));
					acc = NB'(mant);
				end else begin
					acc = (8 * (size - 3) >= NB) ? '0 : NB'(mant) << (8 * (size - 3));
				end
				r.compact_negative = (mant != 0) && (it.data & SIGN_BIT) != 0;
				r.compact_overflow = (mant != 0) && (size > 4 * NW + 2 ||
					(mant > MANT_BYTE && size > 4 * NW + 1) ||
					(mant > MANT_HALF && size > 4 * NW));
			end
			default: ;
		endcase
		r.read_word = acc[it.word_index*32 +: 32];
		r.a_less_b = acc < opnd;
		r.a_equal_b = acc == opnd;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			acc = '0;
			opnd = '0;
			expected_q.delete();
			fail_count = 0;
			beats_seen = 0;
		end else begin
			// result of an earlier command before a new one is logged
			if (result_valid) begin
				if (expected_q.size() == 0) begin
					$display("MISMATCH: result beat with nothing expected");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (result.read_word !== want.read_word)
						report_mismatch("read_word", result.read_word, want.read_word);
					if (result.a_less_b !== want.a_less_b)
						report_mismatch("a_less_b", result.a_less_b, want.a_less_b);
					if (result.a_equal_b !== want.a_equal_b)
						report_mismatch("a_equal_b", result.a_equal_b, want.a_equal_b);
					if (result.div_by_zero !== want.div_by_zero)
						report_mismatch("div_by_zero", result.div_by_zero, want.div_by_zero);
					if (result.compact_negative !== want.compact_negative)
						report_mismatch("compact_negative", result.compact_negative,
							want.compact_negative);
					if (result.compact_overflow !== want.compact_overflow)
						report_mismatch("compact_overflow", result.compact_overflow,
							want.compact_overflow);
				end
				beats_seen++;
			end
			if (start && !busy)
				expected_q.push_back(predict_command(cmd_in));
		end
	end
endmodule

@@ bench/uint256_arith_unit_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the 256-bit integer unit: clock, reset, command stimulus and verdict.
module uint256_arith_unit_top_tb;
	import u256_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_item_t  cmd_in;
	logic      busy;
	logic      result_valid;
	out_item_t result;
	int        fail_count;
	int        pending;
	int        beats_seen;
	int        cycle_count;
	int        div_count;

	localparam int CYCLE_LIMIT = 1500000;

	uint256_arith_unit_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd_in(cmd_in),
		.busy(busy), .result_valid(result_valid), .result(result)
	);

	uint256_arith_unit_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.result_valid(result_valid), .result(result), .fail_count(fail_count),
		.pending(pending), .beats_seen(beats_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** uint256_arith_unit_top: FAILED **");
			$finish;
		end
	end

	// present one command beat and hold it until accepted
	task automatic issue_command(input cmd_t c, input logic [2:0] idx,
			input logic [31:0] d, input bit quiet);
		if (!quiet)
			while ($urandom_range(99) < 36) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start <= 1'b1;
		cmd_in <= '{cmd: c, word_index: idx, data: d};
		do @(posedge clk); while (busy);
		if (c == CMD_DIV) div_count++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return $urandom_range(255);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_command(input bit quiet);
		logic [31:0] d;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			issue_command(CMD_LOADA, 3'($urandom_range(7)), random_word(), quiet);
		end else if (pick < 55) begin
			// sparse B so divides get real quotients, sometimes zero
			issue_command(CMD_LOADB, 3'($urandom_range(7)),
				($urandom_range(2) == 0) ? 32'h0 : random_word(), quiet);
		end else if (pick < 60) begin
			issue_command(CMD_ADD, 3'($urandom_range(7)), $urandom, quiet);
		end else if (pick < 65) begin
			issue_command(CMD_SUB, 3'($urandom_range(7)), $urandom, quiet);
		end else if (pick < 71) begin
			d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
			issue_command(($urandom_range(1) == 0) ? CMD_SHL : CMD_SHR,
				3'($urandom_range(7)), d, quiet);
		end else if (pick < 74) begin
			issue_command(CMD_INV, 3'($urandom_range(7)), $urandom, quiet);
		end else if (pick < 82) begin
			issue_command(CMD_DIV, 3'($urandom_range(7)), $urandom, quiet);
		end else if (pick < 90) begin
			d = $urandom;
			if ($urandom_range(1) == 0) d[31:24] = 8'($urandom_range(40));
			issue_command(CMD_COMPACT, 3'($urandom_range(7)), d, quiet);
		end else begin
			// read, and now and then one of the unused codes
			issue_command(($urandom_range(4) == 0) ? cmd_t'($urandom_range(15, 10)) : CMD_READ,
				3'($urandom_range(7)), $urandom, quiet);
		end
	endtask

	initial begin
		int waited;
		cycle_count = 0;
		div_count = 0;
		start = 1'b0;
		cmd_in = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, the special cases
		for (int i = 0; i < 8; i++) issue_command(CMD_LOADA, 3'(i), 32'hffffffff, 1'b1);
		issue_command(CMD_LOADB, 3'd0, 32'h1, 1'b0);
		issue_command(CMD_ADD, 3'd7, 32'h0, 1'b0);
		issue_command(CMD_SUB, 3'd7, 32'h0, 1'b0);
		issue_command(CMD_SHL, 3'd1, 32'd33, 1'b0);
		issue_command(CMD_SHR, 3'd0, 32'd255, 1'b0);
		issue_command(CMD_SHL, 3'd0, 32'd256, 1'b0);
		issue_command(CMD_INV, 3'd5, 32'h0, 1'b0);
		issue_command(CMD_DIV, 3'd0, 32'h0, 1'b0);
		issue_command(CMD_LOADB, 3'd0, 32'h0, 1'b0);
		issue_command(CMD_DIV, 3'd0, 32'h0, 1'b0);
		issue_command(CMD_COMPACT, 3'd0, 32'h1d00ffff, 1'b0);
		issue_command(CMD_COMPACT, 3'd0, 32'h01fedcba, 1'b0);
		issue_command(CMD_COMPACT, 3'd7, 32'h22ffffff, 1'b0);
		issue_command(CMD_COMPACT, 3'd7, 32'hff800000, 1'b0);
		issue_command(CMD_READ, 3'd7, 32'hffffffff, 1'b0);
		issue_command(cmd_t'(4'd15), 3'd0, 32'h0, 1'b0);

		// random: a quiet stretch first, then random gaps
		for (int n = 0; n < 1700; n++) random_command(n < 200);
		start <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (5) @(posedge clk);

		$display("ran %0d result beats, %0d divides, all ten commands and unused codes",
			beats_seen, div_count);
		if (fail_count == 0 && pending == 0)
			$display("** uint256_arith_unit_top: PASSED **");
		else
			$display("** uint256_arith_unit_top: FAILED **");
		$finish;
	end
endmodule

@@ uint256_arith_unit_top.f @@
rtl/core/u256_pkg.sv
rtl/core/u256_div.sv
rtl/core/uint256_arith_unit_top.sv
bench/uint256_arith_unit_checker.sv
bench/uint256_arith_unit_top_tb.sv
